// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, ignored while reset is held
`define GLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gif lzw encoder check failed");
// Checked property at every edge
`define GLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("gif lzw encoder check failed");
`else
`define GLE_ASSERT(lbl, clk, rst_n, prop)
`define GLE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/gle_pkg.sv =====
package gle_pkg;

  // Code and dictionary geometry
  localparam int CODE_W    = 12;
  localparam int DICT_SIZE = 4096;
  localparam int ROOT_N    = 256;
  localparam int ROOT_W    = 8;
  localparam int ACC_W     = 20;

  localparam logic [3:0] MAX_WIDTH = 4'd12;
  localparam logic [3:0] MCS_MIN   = 4'd2;
  localparam logic [3:0] MCS_MAX   = 4'd8;
  localparam logic [3:0] MCS_RESET = 4'd8;

  typedef logic [CODE_W-1:0] code_t;

  // One dictionary entry: suffix byte, next sibling link, first child link
  typedef struct packed {
    logic [7:0] suffix;
    code_t      sibling;
    code_t      child;
  } dict_word_t;

  // Command to the bit packer
  typedef struct packed {
    code_t      code;
    logic [3:0] width;
    logic       drop;   // discard pending bits before this code
    logic       flush;  // last code of the frame, pad out the final byte
  } pk_cmd_t;

  // Clamp the programmed minimum code size to its legal range
  function automatic logic [3:0] eff_mcs(input logic [3:0] raw);
    logic [3:0] m;
    m = raw;
    if (raw < MCS_MIN) begin
      m = MCS_MIN;
    end else if (raw > MCS_MAX) begin
      m = MCS_MAX;
    end
    return m;
  endfunction

endpackage

// ===== rtl/gle_if.sv =====
// Pixel input channel
interface gle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;
  logic       empty_frame;
  modport source (output valid, pixel, last_pixel, empty_frame, input ready);
  modport sink (input valid, pixel, last_pixel, empty_frame, output ready);
endinterface

// Packed code byte output channel
interface gle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       frame_end;
  modport source (output valid, code_byte, frame_end, input ready);
  modport sink (input valid, code_byte, frame_end, output ready);
endinterface

// Configuration write channel
interface gle_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] root_bits;
  modport source (output valid, root_bits, input ready);
  modport sink (input valid, root_bits, output ready);
endinterface

// ===== rtl/gle_packer.sv =====
`include "assert_macros.svh"

module gle_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  gle_pkg::pk_cmd_t  cmd,
  gle_byte_if.source        out_byte
);

  logic [gle_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      flush_r, flush_nxt;
  logic                      busy_r, busy_nxt;
  logic                      ob_valid_r, ob_valid_nxt;
  logic [7:0]                ob_byte_r, ob_byte_nxt;
  logic                      ob_end_r, ob_end_nxt;

  logic                      out_free;
  logic [3:0]                w;
  logic [gle_pkg::ACC_W-1:0] mask;
  logic [gle_pkg::ACC_W-1:0] base_acc;
  logic [4:0]                base_cnt;

  assign out_free  = !ob_valid_r || out_byte.ready;
  assign cmd_ready = !busy_r;

  // Code masking and alignment
  assign w        = (cmd.width > gle_pkg::MAX_WIDTH) ? gle_pkg::MAX_WIDTH : cmd.width;
  assign mask     = (gle_pkg::ACC_W'(1) << w) - gle_pkg::ACC_W'(1);
  assign base_acc = cmd.drop ? '0 : acc_r;
  assign base_cnt = cmd.drop ? '0 : cnt_r;

  // Append codes, then drain whole bytes one beat at a time
  always_comb begin
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    flush_nxt    = flush_r;
    busy_nxt     = busy_r;
    ob_valid_nxt = ob_valid_r;
    ob_byte_nxt  = ob_byte_r;
    ob_end_nxt   = ob_end_r;
    if (ob_valid_r && out_byte.ready) begin
      ob_valid_nxt = 1'b0;
    end
    if (!busy_r) begin
      if (cmd_valid) begin
        acc_nxt   = base_acc | ((gle_pkg::ACC_W'(cmd.code) & mask) << base_cnt[2:0]);
        cnt_nxt   = base_cnt + 5'(w);
        flush_nxt = cmd.flush;
        busy_nxt  = 1'b1;
      end
    end else if (out_free) begin
      if (cnt_r >= 5'd8) begin
        ob_valid_nxt = 1'b1;
        ob_byte_nxt  = acc_r[7:0];
        ob_end_nxt   = flush_r && (cnt_r == 5'd8);
        acc_nxt      = acc_r >> 8;
        cnt_nxt      = cnt_r - 5'd8;
      end else if (flush_r && (cnt_r != 5'd0)) begin
        // partial last byte of the frame
        ob_valid_nxt = 1'b1;
        ob_byte_nxt  = acc_r[7:0];
        ob_end_nxt   = 1'b1;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        flush_nxt    = 1'b0;
        busy_nxt     = 1'b0;
      end else begin
        busy_nxt  = 1'b0;
        flush_nxt = 1'b0;
        if (flush_r) begin
          acc_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      cnt_r      <= '0;
      flush_r    <= 1'b0;
      busy_r     <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      flush_r    <= flush_nxt;
      busy_r     <= busy_nxt;
      ob_valid_r <= ob_valid_nxt;
    end
    ob_byte_r <= ob_byte_nxt;
    ob_end_r  <= ob_end_nxt;
  end

  assign out_byte.valid     = ob_valid_r;
  assign out_byte.code_byte = ob_byte_r;
  assign out_byte.frame_end = ob_end_r;

  // Checks
  `GLE_ASSERT(a_idle_partial, clk, rst_n, !busy_r |-> cnt_r < 5'd8)
  `GLE_ASSERT(a_cnt_bound, clk, rst_n, cnt_r < 5'd20)
  `GLE_ASSERT(a_flush_empties, clk, rst_n, (busy_r && out_free && flush_r && cnt_r != 5'd0 && cnt_r <= 5'd8) |=> cnt_r == 5'd0)

endmodule

// ===== rtl/gle_dict_ctrl.sv =====
`include "assert_macros.svh"

module gle_dict_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  gle_pix_if.sink           in_pix,
  gle_cfg_if.sink           cfg_wr,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output gle_pkg::pk_cmd_t  cmd
);

  localparam logic [12:0] NFC_FULL = 13'(gle_pkg::DICT_SIZE - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_WALK, S_MISS, S_WR_NODE, S_WR_PAR, S_FULL, S_START, S_FIN, S_END
  } state_t;

  state_t                     state_r, state_nxt;
  logic [3:0]                 mcs_r, mcs_nxt;
  logic                       open_r, open_nxt;
  gle_pkg::code_t             cur_r, cur_nxt;
  logic [7:0]                 px_r, px_nxt;
  logic                       last_r, last_nxt;
  logic                       empty_r, empty_nxt;
  gle_pkg::code_t             e_r, e_nxt;
  gle_pkg::code_t             child_cur_r, child_cur_nxt;
  logic [7:0]                 cur_suf_r, cur_suf_nxt;
  gle_pkg::code_t             cur_sib_r, cur_sib_nxt;
  logic [12:0]                nfc_r, nfc_nxt;
  logic [3:0]                 width_r, width_nxt;
  logic [gle_pkg::ROOT_N-1:0] vld_r, vld_nxt;

  // Dictionary memory, registered read
  gle_pkg::dict_word_t dict_mem [gle_pkg::DICT_SIZE];
  gle_pkg::dict_word_t rdata_r;
  gle_pkg::dict_word_t wr_data;
  gle_pkg::code_t      rd_addr, wr_addr;
  logic                rd_en, wr_en;

  logic [3:0]     m;
  gle_pkg::code_t clr_code;
  gle_pkg::code_t end_code;
  logic [7:0]     px_in;
  logic [12:0]    nfc_start;
  logic [3:0]     width_start;
  logic           cur_root;
  gle_pkg::code_t look_child;
  logic [12:0]    nfc_inc;
  logic [3:0]     width_inc;

  // Derived code values
  assign m           = gle_pkg::eff_mcs(mcs_r);
  assign clr_code    = gle_pkg::code_t'(1) << m;
  assign end_code    = clr_code + gle_pkg::code_t'(1);
  assign px_in       = in_pix.pixel & 8'(clr_code - gle_pkg::code_t'(1));
  assign nfc_start   = 13'(clr_code) + 13'd2;
  assign width_start = m + 4'd1;
  assign cur_root    = cur_r < clr_code;
  assign look_child  = (cur_root && !vld_r[cur_r[gle_pkg::ROOT_W-1:0]]) ? '0 : rdata_r.child;
  assign nfc_inc     = nfc_r + 13'd1;
  assign width_inc   = ((nfc_inc > (13'd1 << width_r)) && (width_r < gle_pkg::MAX_WIDTH)) ?
                       width_r + 4'd1 : width_r;

  assign cfg_wr.ready = (state_r == S_IDLE);
  assign in_pix.ready = (state_r == S_IDLE) && !cfg_wr.valid;

  // Sequencer: lookup, sibling walk, entry insert, code issue
  always_comb begin
    state_nxt     = state_r;
    mcs_nxt       = mcs_r;
    open_nxt      = open_r;
    cur_nxt       = cur_r;
    px_nxt        = px_r;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    e_nxt         = e_r;
    child_cur_nxt = child_cur_r;
    cur_suf_nxt   = cur_suf_r;
    cur_sib_nxt   = cur_sib_r;
    nfc_nxt       = nfc_r;
    width_nxt     = width_r;
    vld_nxt       = vld_r;
    rd_en         = 1'b0;
    rd_addr       = cur_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = '{suffix: cur_suf_r, sibling: cur_sib_r, child: nfc_r[11:0]};
    cmd_valid     = 1'b0;
    cmd           = '{code: cur_r, width: width_r, drop: 1'b0, flush: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (cfg_wr.valid) begin
          mcs_nxt  = cfg_wr.root_bits;
          open_nxt = 1'b0;
        end else if (in_pix.valid) begin
          px_nxt    = px_in;
          last_nxt  = in_pix.last_pixel;
          empty_nxt = in_pix.empty_frame;
          if (in_pix.empty_frame || !open_r) begin
            // new frame: fresh table
            nfc_nxt   = nfc_start;
            width_nxt = width_start;
            vld_nxt   = '0;
            open_nxt  = !in_pix.empty_frame;
            cur_nxt   = gle_pkg::code_t'(px_in);
            state_nxt = S_START;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = cur_r;
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        cur_suf_nxt   = rdata_r.suffix;
        cur_sib_nxt   = rdata_r.sibling;
        child_cur_nxt = look_child;
        if (look_child == '0) begin
          state_nxt = S_MISS;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = look_child;
          e_nxt     = look_child;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (rdata_r.suffix == px_r) begin
          cur_nxt   = e_r;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (rdata_r.sibling == '0) begin
          state_nxt = S_MISS;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = rdata_r.sibling;
          e_nxt     = rdata_r.sibling;
        end
      end
      S_MISS: begin
        cmd_valid = 1'b1;
        cmd       = '{code: cur_r, width: width_r, drop: 1'b0, flush: 1'b0};
        if (cmd_ready) begin
          state_nxt = S_WR_NODE;
        end
      end
      S_WR_NODE: begin
        // new entry heads the parent's child list
        wr_en     = 1'b1;
        wr_addr   = nfc_r[11:0];
        wr_data   = '{suffix: px_r, sibling: child_cur_r, child: '0};
        state_nxt = S_WR_PAR;
      end
      S_WR_PAR: begin
        wr_en     = 1'b1;
        wr_addr   = cur_r;
        wr_data   = '{suffix: cur_suf_r, sibling: cur_sib_r, child: nfc_r[11:0]};
        if (cur_root) begin
          vld_nxt[cur_r[gle_pkg::ROOT_W-1:0]] = 1'b1;
        end
        nfc_nxt   = nfc_inc;
        width_nxt = width_inc;
        cur_nxt   = gle_pkg::code_t'(px_r);
        if (nfc_inc >= NFC_FULL) begin
          state_nxt = S_FULL;
        end else begin
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FULL: begin
        cmd_valid = 1'b1;
        cmd       = '{code: clr_code, width: width_r, drop: 1'b0, flush: 1'b0};
        if (cmd_ready) begin
          nfc_nxt   = nfc_start;
          width_nxt = width_start;
          vld_nxt   = '0;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_START: begin
        cmd_valid = 1'b1;
        cmd       = '{code: clr_code, width: width_r, drop: 1'b1, flush: 1'b0};
        if (cmd_ready) begin
          if (empty_r) begin
            state_nxt = S_END;
          end else begin
            state_nxt = last_r ? S_FIN : S_IDLE;
          end
        end
      end
      S_FIN: begin
        cmd_valid = 1'b1;
        cmd       = '{code: cur_r, width: width_r, drop: 1'b0, flush: 1'b0};
        if (cmd_ready) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        cmd_valid = 1'b1;
        cmd       = '{code: end_code, width: width_r, drop: 1'b0, flush: 1'b1};
        if (cmd_ready) begin
          open_nxt  = 1'b0;
          cur_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mcs_r   <= gle_pkg::MCS_RESET;
      open_r  <= 1'b0;
      cur_r   <= '0;
      nfc_r   <= 13'(gle_pkg::code_t'(1) << gle_pkg::MCS_RESET) + 13'd2;
      width_r <= gle_pkg::MCS_RESET + 4'd1;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mcs_r   <= mcs_nxt;
      open_r  <= open_nxt;
      cur_r   <= cur_nxt;
      nfc_r   <= nfc_nxt;
      width_r <= width_nxt;
      vld_r   <= vld_nxt;
    end
    px_r        <= px_nxt;
    last_r      <= last_nxt;
    empty_r     <= empty_nxt;
    e_r         <= e_nxt;
    child_cur_r <= child_cur_nxt;
    cur_suf_r   <= cur_suf_nxt;
    cur_sib_r   <= cur_sib_nxt;
  end

  // Dictionary memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dict_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= dict_mem[rd_addr];
    end
  end

  // Checks
  `GLE_ASSERT(a_nfc_bound, clk, rst_n, nfc_r <= NFC_FULL)
  `GLE_ASSERT(a_walk_link, clk, rst_n, (state_r == S_WALK) |-> (e_r != '0))
  `GLE_ASSERT(a_width_bound, clk, rst_n, width_r <= gle_pkg::MAX_WIDTH)
  `GLE_ASSERT(a_insert_count, clk, rst_n, (state_r == S_WR_PAR) |=> (nfc_r == $past(nfc_r) + 13'd1))

endmodule

// ===== rtl/gif_lzw_encoder.sv =====
// GIF LZW encoder, variable code width up to 12 bits, LSB-first byte packing.
// in_pix: one palette index per beat, with last_pixel marking the frame's final
//   pixel and empty_frame giving a frame without pixels (clear, end, pad byte).
// out_byte: packed code bytes, frame_end set on the frame's final byte.
// cfg_wr: writes the code size; taken only between items, starts a new frame.
// Per pixel the dictionary is read once for the current string's child link,
// then once per child visited. A miss adds one code beat and two memory writes.
// The packer takes a code, then sends each finished byte on its own beat and
// goes idle before it takes the next code.
// The dictionary memory, with at most one access per cycle, sets the pace.
// A code is first appended to the packer's accumulator; its finished bytes then
// move to the output byte register.
// Reset: code size 8, no frame open, output empty; the dictionary needs no
// clearing pass, root child links are cleared by valid bits at each restart.
// A stalled out_byte holds its byte; the packer takes at most one more code and
// then stops taking codes, the sequencer waits at its next code beat, and in_pix
// stays not ready from then until the packer frees up.
module gif_lzw_encoder (
  input  logic        clk,
  input  logic        rst_n,
  gle_pix_if.sink     in_pix,
  gle_byte_if.source  out_byte,
  gle_cfg_if.sink     cfg_wr
);

  gle_pkg::pk_cmd_t cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  gle_dict_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .cfg_wr    (cfg_wr),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  gle_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_byte  (out_byte)
  );

endmodule

// ===== tb/gif_lzw_encoder_test.sv =====
`timescale 1ns / 1ps

module gif_lzw_encoder_test;

  localparam int QUIET    = 40;       // cycles allowed after the last byte for late output
  localparam int HOLD_LEN = 600;      // long receiver hold-off
  // ~360 pixels, each at worst a long sibling walk, sender gaps and 8 stalled bytes
  localparam int unsigned LIMIT = 500000;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
    logic       empty_frame;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       frame_end;
  } code_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  gle_pix_if  pix_ch ();
  gle_byte_if byte_ch ();
  gle_cfg_if  cfg_ch ();

  gif_lzw_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_ch),
    .out_byte (byte_ch),
    .cfg_wr   (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pix_beat_t   pix_backlog[$];
  logic [3:0]  mcs_backlog[$];
  code_beat_t  code_bytes_due[$];
  pix_beat_t   pix_next;
  code_beat_t  byte_want;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          err_cnt = 0;
  int          hold_cnt = 0;
  logic        hold_go = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned cycle_cnt = 0;

  // Encoder shadow: dictionary, open string, code width and bit packer
  logic [7:0]     sfx_mem [gle_pkg::DICT_SIZE];
  gle_pkg::code_t kid_mem [gle_pkg::DICT_SIZE];
  gle_pkg::code_t sib_mem [gle_pkg::DICT_SIZE];
  gle_pkg::code_t str_code;
  logic           str_open;
  logic [12:0]    free_code;
  logic [3:0]     code_w;
  logic [23:0]    bit_acc;
  logic [4:0]     bit_cnt;
  logic [3:0]     mcs_reg;
  int             step_bytes;

  // out-of-range sizes act as the nearest legal one
  function automatic int mcs_eff();
    int m;
    m = int'(mcs_reg);
    if (m < 2) begin
      m = 2;
    end else if (m > 8) begin
      m = 8;
    end
    return m;
  endfunction

  function automatic int clear_of();
    return 1 << mcs_eff();
  endfunction

  function automatic void restart_dict();
    for (int i = 0; i < gle_pkg::DICT_SIZE; i++) begin
      kid_mem[i] = '0;
    end
    free_code = 13'(clear_of() + 2);
    code_w = 4'(mcs_eff() + 1);
  endfunction

  function automatic void go_idle();
    restart_dict();
    str_code = '0;
    str_open = 1'b0;
    bit_acc = '0;
    bit_cnt = '0;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    code_beat_t cb;
    cb.code_byte = b;
    cb.frame_end = 1'b0;
    code_bytes_due.push_back(cb);
    step_bytes++;
  endfunction

  // append one code LSB first, emitting every finished byte
  function automatic void pack_code(input int code);
    int          w;
    logic [31:0] acc;
    int          cnt;
    w = int'(code_w);
    if (w > int'(gle_pkg::MAX_WIDTH)) begin
      w = int'(gle_pkg::MAX_WIDTH);
    end
    code = code & ((1 << w) - 1);
    acc = {8'd0, bit_acc} | 32'(code << bit_cnt);
    cnt = int'(bit_cnt) + w;
    while (cnt >= 8) begin
      push_byte(acc[7:0]);
      acc = acc >> 8;
      cnt = cnt - 8;
    end
    bit_acc = acc[23:0];
    bit_cnt = 5'(cnt);
  endfunction

  function automatic void close_frame(input logic with_cur);
    code_beat_t cb;
    if (with_cur) begin
      pack_code(int'(str_code));
    end
    pack_code(clear_of() + 1);
    if (bit_cnt > 0) begin
      push_byte(bit_acc[7:0]);
    end
    bit_acc = '0;
    bit_cnt = '0;
    str_open = 1'b0;
    str_code = '0;
    if (step_bytes > 0) begin
      cb = code_bytes_due.pop_back();
      cb.frame_end = 1'b1;
      code_bytes_due.push_back(cb);
    end
  endfunction

  // look for string+px among the children; on a miss emit, add entry, maybe widen/clear
  function automatic void grow_string(input logic [7:0] px);
    gle_pkg::code_t cur;
    gle_pkg::code_t e;
    gle_pkg::code_t n;
    int             guard;
    cur = str_code;
    e = kid_mem[cur];
    guard = 0;
    while (e != 0 && guard < gle_pkg::DICT_SIZE) begin
      if (sfx_mem[e] == px) begin
        str_code = e;
        return;
      end
      e = sib_mem[e];
      guard++;
    end
    pack_code(int'(cur));
    if (free_code < gle_pkg::DICT_SIZE) begin
      n = free_code[11:0];
      sfx_mem[n] = px;
      kid_mem[n] = '0;
      sib_mem[n] = kid_mem[cur];
      kid_mem[cur] = n;
      free_code++;
    end
    if (free_code > (1 << code_w) && code_w < gle_pkg::MAX_WIDTH) begin
      code_w++;
    end
    if (free_code >= gle_pkg::DICT_SIZE - 1) begin
      pack_code(clear_of());
      restart_dict();
    end
    str_code = gle_pkg::code_t'(px);
  endfunction

  function automatic void encode_pixel(input logic [7:0] pixel, input logic last,
                                       input logic empty);
    logic [7:0] px;
    px = 8'(int'(pixel) & ((1 << mcs_eff()) - 1));
    step_bytes = 0;
    if (empty) begin
      go_idle();
      pack_code(clear_of());
      close_frame(1'b0);
      return;
    end
    if (!str_open) begin
      go_idle();
      pack_code(clear_of());
      str_code = gle_pkg::code_t'(px);
      str_open = 1'b1;
    end else begin
      grow_string(px);
    end
    if (last) begin
      close_frame(1'b1);
    end
  endfunction

  function automatic void load_mcs(input logic [3:0] v);
    mcs_reg = v;
    go_idle();
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < gle_pkg::DICT_SIZE; i++) begin
      sfx_mem[i] = '0;
      sib_mem[i] = '0;
    end
    mcs_reg = gle_pkg::MCS_RESET;
    go_idle();
  endfunction

  // Pixel driver; the shadow encoder advances on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid       <= 1'b0;
      pix_ch.pixel       <= '0;
      pix_ch.last_pixel  <= 1'b0;
      pix_ch.empty_frame <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        encode_pixel(pix_ch.pixel, pix_ch.last_pixel, pix_ch.empty_frame);
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pix_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          pix_next = pix_backlog.pop_front();
          pix_ch.valid       <= 1'b1;
          pix_ch.pixel       <= pix_next.pixel;
          pix_ch.last_pixel  <= pix_next.last_pixel;
          pix_ch.empty_frame <= pix_next.empty_frame;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Config driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid     <= 1'b0;
      cfg_ch.root_bits <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        load_mcs(cfg_ch.root_bits);
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (mcs_backlog.size() != 0) begin
          cfg_ch.valid     <= 1'b1;
          cfg_ch.root_bits <= mcs_backlog.pop_front();
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by toggling hold_go
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go != hold_ack) begin
      hold_cnt <= HOLD_LEN;
      hold_ack <= hold_go;
    end
  end

  // Byte monitor: compare each beat with the oldest expected byte
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.ready <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (code_bytes_due.size() == 0) begin
          $error("code_byte beat with nothing expected: got %02h", byte_ch.code_byte);
          err_cnt++;
        end else begin
          byte_want = code_bytes_due.pop_front();
          if (byte_ch.code_byte !== byte_want.code_byte) begin
            $error("code_byte mismatch: expected %02h, got %02h",
                   byte_want.code_byte, byte_ch.code_byte);
            err_cnt++;
          end
          if (byte_ch.frame_end !== byte_want.frame_end) begin
            $error("frame_end mismatch: expected %0b, got %0b",
                   byte_want.frame_end, byte_ch.frame_end);
            err_cnt++;
          end
        end
      end
      byte_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] p, input logic last, input logic empty);
    pix_beat_t b;
    b.pixel = p;
    b.last_pixel = last;
    b.empty_frame = empty;
    pix_backlog.push_back(b);
  endtask

  // wait until every pixel is taken and every byte has come, then let the block go quiet
  task automatic settle();
    do @(negedge clk);
    while (pix_backlog.size() != 0 || pix_ch.valid || code_bytes_due.size() != 0);
    repeat (QUIET) @(negedge clk);
  endtask

  task automatic write_mcs(input logic [3:0] v);
    settle();
    mcs_backlog.push_back(v);
    do @(negedge clk);
    while (mcs_backlog.size() != 0 || cfg_ch.valid);
  endtask

  task automatic set_idle(input int in_pct, input int out_pct);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
  endtask

  // symbol in the low m bits, random bits above that the block must mask
  function automatic logic [7:0] pick_pixel(input int alpha, input int m);
    int sym;
    int hi;
    sym = int'($urandom_range(alpha - 1));
    hi = int'($urandom_range(255));
    return 8'((hi << m) | sym);
  endfunction

  // Frames of random length over small or full alphabets, with empty
  // frames and frames broken off by an empty frame mixed in
  task automatic random_frames(input int n_items, input int raw_mcs);
    int sent;
    int flen;
    int alpha;
    int m;
    sent = 0;
    m = (raw_mcs < 2) ? 2 : (raw_mcs > 8) ? 8 : raw_mcs;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        push_pixel(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        sent++;
      end else begin
        flen = ($urandom_range(7) == 0) ? int'($urandom_range(40, 120)) :
                                          int'($urandom_range(1, 25));
        case ($urandom_range(2))
          0: alpha = 2;
          1: alpha = 5;
          default: alpha = 1 << m;
        endcase
        if (alpha > (1 << m)) begin
          alpha = 1 << m;
        end
        for (int k = 0; k < flen && sent < n_items; k++) begin
          if ($urandom_range(59) == 0) begin
            push_pixel(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
          end else begin
            push_pixel(pick_pixel(alpha, m), k == flen - 1, 1'b0);
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    reset_model();
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset size 8: empty frame, single-pixel frame, repeats that extend
    push_pixel(8'hA5, 1'b1, 1'b1);
    push_pixel(8'h00, 1'b1, 1'b0);
    repeat (4) push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b1, 1'b0);
    // open frame dropped by an empty frame
    push_pixel(8'h00, 1'b0, 1'b0);
    push_pixel(8'h01, 1'b0, 1'b0);
    push_pixel(8'h00, 1'b0, 1'b0);
    push_pixel(8'h01, 1'b0, 1'b0);
    push_pixel(8'h3C, 1'b0, 1'b1);
    push_pixel(8'h80, 1'b0, 1'b0);
    push_pixel(8'h07, 1'b1, 1'b0);
    // smallest size, upper pixel bits masked off
    write_mcs(4'd2);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'hFC, 1'b0, 1'b0);
    push_pixel(8'h03, 1'b0, 1'b0);
    push_pixel(8'h02, 1'b0, 1'b0);
    push_pixel(8'h01, 1'b1, 1'b0);
    // size below range acts as 2; frame left open, aborted by the next write
    write_mcs(4'd0);
    push_pixel(8'h01, 1'b0, 1'b0);
    push_pixel(8'h02, 1'b0, 1'b0);
    // size above range acts as 8
    write_mcs(4'd15);
    push_pixel(8'hC8, 1'b1, 1'b0);

    // Random phases across sizes and idling mixes
    write_mcs(4'd2);
    set_idle(0, 0);
    random_frames(60, 2);

    write_mcs(4'd8);
    set_idle(75, 0);
    random_frames(30, 8);
    settle();
    random_frames(30, 8);

    // receiver holds off while the sender keeps offering
    write_mcs(4'd5);
    set_idle(0, 75);
    random_frames(30, 5);
    hold_go = ~hold_go;
    random_frames(40, 5);

    write_mcs(4'd1);
    set_idle(15, 15);
    random_frames(40, 1);

    write_mcs(4'd9);
    set_idle(0, 0);
    random_frames(40, 9);

    write_mcs(4'd3);
    set_idle(75, 75);
    random_frames(40, 3);

    // One longer frame at the smallest size: codes widen several times
    write_mcs(4'd2);
    set_idle(15, 15);
    for (int i = 0; i < 30; i++) begin
      push_pixel(pick_pixel(4, 2), i == 29, 1'b0);
    end

    settle();
    if (err_cnt == 0 && code_bytes_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gle_pkg.sv
rtl/gle_if.sv
rtl/gle_packer.sv
rtl/gle_dict_ctrl.sv
rtl/gif_lzw_encoder.sv
tb/gif_lzw_encoder_test.sv
